### sv/dbsu_pkg.sv
// Shared types and constants of the debug breakpoint and single-step unit.
package dbsu_pkg;

  localparam int THREADS     = 16;
  localparam int BREAKPOINTS = 16;
  localparam int ADDR_BITS   = 32;

  localparam int THR_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int BP_W  = (BREAKPOINTS > 1) ? $clog2(BREAKPOINTS) : 1;

  localparam int KIND_W   = 4;
  localparam int THREAD_W = 4;
  localparam int CODE_W   = 32;
  localparam int LINE_W   = 16;
  localparam int DEPTH_W  = 8;
  localparam int SLOT_W   = 4;
  localparam int REASON_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXEC     = 4'd0,
    KIND_CONTINUE = 4'd1,
    KIND_OVER     = 4'd2,
    KIND_IN       = 4'd3,
    KIND_OUT      = 4'd4,
    KIND_PAUSE    = 4'd5,
    KIND_ATTACH   = 4'd6,
    KIND_DETACH   = 4'd7,
    KIND_BP_WRITE = 4'd8,
    KIND_BP_CLEAR = 4'd9,
    KIND_RELEASE  = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_OVER = 2'd1,
    MODE_IN   = 2'd2,
    MODE_OUT  = 2'd3
  } mode_t;

  typedef enum logic [REASON_W-1:0] {
    WHY_NONE  = 2'd0,
    WHY_BP    = 2'd1,
    WHY_STEP  = 2'd2,
    WHY_PAUSE = 2'd3
  } reason_t;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [THREAD_W-1:0] thread;
    addr_t               addr;
    logic [LINE_W-1:0]   line;
    logic [DEPTH_W-1:0]  depth;
    logic [SLOT_W-1:0]   slot;
    logic                en;
  } item_t;

  typedef struct packed {
    logic                hold;
    logic                stopped_event;
    reason_t             reason;
    logic [THREAD_W-1:0] event_thread;
  } res_t;

  typedef struct packed {
    logic            wr;
    logic            clr;
    logic [BP_W-1:0] slot;
    addr_t           addr;
    logic            en;
  } bp_cmd_t;

  typedef struct packed {
    logic               paused;
    mode_t              mode;
    logic [DEPTH_W-1:0] depth;
    logic [LINE_W-1:0]  line;
    addr_t              ign_addr;
    logic               ign_v;
  } thr_t;

endpackage

### sv/dbsu_if.sv
// Request and result channel interfaces of the debug breakpoint and single-step unit.
interface dbsu_in_if;
  import dbsu_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [THREAD_W-1:0] thread;
  logic [CODE_W-1:0]   code_addr;
  logic [LINE_W-1:0]   line;
  logic [DEPTH_W-1:0]  depth;
  logic [SLOT_W-1:0]   bp_index;
  logic                bp_enable;

  modport source (
    output valid, kind, thread, code_addr, line, depth, bp_index, bp_enable,
    input  ready
  );
  modport sink (
    input  valid, kind, thread, code_addr, line, depth, bp_index, bp_enable,
    output ready
  );
endinterface

interface dbsu_out_if;
  import dbsu_pkg::*;

  logic                valid;
  logic                ready;
  logic                hold;
  logic                stopped_event;
  logic [REASON_W-1:0] reason;
  logic [THREAD_W-1:0] event_thread;

  modport source (
    output valid, hold, stopped_event, reason, event_thread,
    input  ready
  );
  modport sink (
    input  valid, hold, stopped_event, reason, event_thread,
    output ready
  );
endinterface

### sv/debug_breakpoint_step_unit.sv
// Top level of the debug breakpoint and single-step unit: request register, decision and result register.
// The unit takes one request per clock cycle while the output channel is not stalled:
// a request is registered on entry, evaluated against the breakpoint table and the thread's debug
// state in the following cycle, and the result is registered for the output channel while the
// thread state is updated in the same edge. All breakpoint slots are compared in parallel, so the
// rate is set only by that single evaluation stage; a stalled output holds the stages behind it.
module debug_breakpoint_step_unit (
  input logic        clk,
  input logic        rst_n,
  dbsu_in_if.sink    in_ch,
  dbsu_out_if.source out_ch
);
  import dbsu_pkg::*;

  logic    s1_v_r;
  item_t   s1_r;
  logic    o_v_r;
  res_t    o_r;
  logic    out_free;
  logic    adv;
  logic    in_fire;
  logic    hit;
  res_t    res;
  bp_cmd_t bp_cmd;

  assign out_free    = !o_v_r || out_ch.ready;
  assign adv         = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (out_free) begin
        o_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.kind   <= in_ch.kind;
      s1_r.thread <= in_ch.thread;
      s1_r.addr   <= ADDR_BITS'(in_ch.code_addr);
      s1_r.line   <= in_ch.line;
      s1_r.depth  <= in_ch.depth;
      s1_r.slot   <= in_ch.bp_index;
      s1_r.en     <= in_ch.bp_enable;
    end
    if (adv) begin
      o_r <= res;
    end
  end

  dbsu_bp_table u_bp_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .bp_cmd      (bp_cmd),
    .lookup_addr (s1_r.addr),
    .hit         (hit)
  );

  dbsu_thread_ctx u_thread_ctx (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .item   (s1_r),
    .hit    (hit),
    .res    (res),
    .bp_cmd (bp_cmd)
  );

  assign out_ch.valid         = o_v_r;
  assign out_ch.hold          = o_r.hold;
  assign out_ch.stopped_event = o_r.stopped_event;
  assign out_ch.reason        = o_r.reason;
  assign out_ch.event_thread  = o_r.event_thread;

  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.stopped_event && out_ch.reason != WHY_PAUSE |-> out_ch.hold)
    else $error("breakpoint or step stop without hold");

  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.stopped_event |-> out_ch.reason == WHY_NONE &&
      out_ch.event_thread == '0)
    else $error("reason or thread set without a stopped notification");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && o_v_r && !out_ch.ready |=> s1_v_r && $stable(s1_r))
    else $error("pending request lost while the output stalls");

endmodule

### sv/dbsu_bp_table.sv
// Breakpoint address table with a parallel match against the current code address.
module dbsu_bp_table (
  input  logic             clk,
  input  logic             rst_n,
  input  dbsu_pkg::bp_cmd_t bp_cmd,
  input  dbsu_pkg::addr_t  lookup_addr,
  output logic             hit
);
  import dbsu_pkg::*;

  logic [BREAKPOINTS-1:0] valid_r;
  addr_t                  addr_r [BREAKPOINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < BREAKPOINTS; i++) begin
        addr_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < BREAKPOINTS; i++) begin
        if (bp_cmd.clr) begin
          valid_r[i] <= 1'b0;
        end else if (bp_cmd.wr && bp_cmd.slot == BP_W'(i)) begin
          valid_r[i] <= bp_cmd.en;
          addr_r[i]  <= bp_cmd.addr;
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < BREAKPOINTS; i++) begin
      hit = hit | (valid_r[i] && addr_r[i] == lookup_addr);
    end
  end

endmodule

### sv/dbsu_thread_ctx.sv
// Per-thread debug state and the stop decision for one request.
module dbsu_thread_ctx (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  dbsu_pkg::item_t   item,
  input  logic              hit,
  output dbsu_pkg::res_t    res,
  output dbsu_pkg::bp_cmd_t bp_cmd
);
  import dbsu_pkg::*;

  logic             attached_r;
  logic             attached_nxt;
  thr_t             thr_r [THREADS];
  thr_t             thr_nxt;
  thr_t             cur;
  logic             thr_we;
  logic [THR_W-1:0] t;
  logic             tok;
  logic             slot_ok;
  logic             ign_match;
  logic             changed;
  logic             step_stop;

  always_comb begin
    t            = THR_W'(item.thread);
    tok          = int'(item.thread) < THREADS;
    slot_ok      = int'(item.slot) < BREAKPOINTS;
    cur          = thr_r[t];
    thr_nxt      = cur;
    thr_we       = 1'b0;
    attached_nxt = attached_r;
    res          = '0;
    bp_cmd       = '0;
    bp_cmd.slot  = BP_W'(item.slot);
    bp_cmd.addr  = item.addr;
    bp_cmd.en    = item.en;
    ign_match    = cur.ign_v && cur.ign_addr == item.addr;
    changed      = item.line != cur.line;

    unique case (cur.mode)
      MODE_IN:   step_stop = changed;
      MODE_OVER: step_stop = (item.depth <= cur.depth) && changed;
      MODE_OUT:  step_stop = item.depth < cur.depth;
      MODE_NONE: step_stop = 1'b0;
      default:   step_stop = 1'b0;
    endcase

    unique case (kind_t'(item.kind))
      KIND_EXEC: begin
        if (attached_r && tok) begin
          if (cur.paused) begin
            res.hold = 1'b1;
          end else begin
            thr_we = 1'b1;
            if (hit && !ign_match) begin
              thr_nxt.paused    = 1'b1;
              thr_nxt.mode      = MODE_NONE;
              res.hold          = 1'b1;
              res.stopped_event = 1'b1;
              res.reason        = WHY_BP;
            end else begin
              // A breakpoint passed once after resuming, or none at all: the mark is spent.
              thr_nxt.ign_v    = 1'b0;
              thr_nxt.ign_addr = '0;
              if (step_stop) begin
                thr_nxt.paused    = 1'b1;
                thr_nxt.mode      = MODE_NONE;
                res.hold          = 1'b1;
                res.stopped_event = 1'b1;
                res.reason        = WHY_STEP;
              end
            end
          end
        end
      end
      KIND_CONTINUE, KIND_OVER, KIND_IN, KIND_OUT: begin
        if (tok) begin
          thr_we           = 1'b1;
          thr_nxt.paused   = 1'b0;
          thr_nxt.ign_addr = item.addr;
          thr_nxt.ign_v    = 1'b1;
          unique case (kind_t'(item.kind))
            KIND_OVER: begin
              thr_nxt.mode  = MODE_OVER;
              thr_nxt.depth = item.depth;
              thr_nxt.line  = item.line;
            end
            KIND_IN: begin
              thr_nxt.mode = MODE_IN;
              thr_nxt.line = item.line;
            end
            KIND_OUT: begin
              thr_nxt.mode  = MODE_OUT;
              thr_nxt.depth = item.depth;
            end
            default: begin
              thr_nxt.mode = MODE_NONE;
            end
          endcase
        end
      end
      KIND_PAUSE: begin
        if (tok) begin
          thr_we            = 1'b1;
          thr_nxt.paused    = 1'b1;
          res.stopped_event = 1'b1;
          res.reason        = WHY_PAUSE;
        end
      end
      KIND_ATTACH:   attached_nxt = 1'b1;
      KIND_DETACH:   attached_nxt = 1'b0;
      KIND_BP_WRITE: bp_cmd.wr    = slot_ok;
      KIND_BP_CLEAR: bp_cmd.clr   = 1'b1;
      KIND_RELEASE: begin
        if (tok) begin
          thr_we  = 1'b1;
          thr_nxt = '0;
        end
      end
      default: begin
      end
    endcase

    if (res.stopped_event) begin
      res.event_thread = item.thread;
    end
    if (!fire) begin
      bp_cmd.wr  = 1'b0;
      bp_cmd.clr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        thr_r[i] <= '0;
      end
    end else if (fire) begin
      attached_r <= attached_nxt;
      if (thr_we) begin
        thr_r[t] <= thr_nxt;
      end
    end
  end

  a_stop_pauses: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.stopped_event |=> thr_r[$past(t)].paused)
    else $error("stopped thread is not marked paused");

  a_exec_detached_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.kind == KIND_EXEC && !attached_r |-> !res.hold && !res.stopped_event)
    else $error("execution request acted on while detached");

endmodule
